// ===== rtl/core/ofq_pkg.sv =====
// ----------------------------------------------------------------------------
// ofq_pkg
// Shared types, codes and defaults of the order queue with served history.
// ----------------------------------------------------------------------------
package ofq_pkg;

    localparam int OFQ_QUEUE_DEPTH   = 16;
    localparam int OFQ_HISTORY_DEPTH = 16;
    localparam int OFQ_MAX_RESULTS   = 16;

    localparam int OFQ_ACT_W    = 3;
    localparam int OFQ_STATUS_W = 2;
    localparam int OFQ_POS_W    = 5;
    localparam int OFQ_CUST_W   = 16;
    localparam int OFQ_ITEM_W   = 8;
    localparam int OFQ_PRICE_W  = 24;

    localparam logic [OFQ_ACT_W-1:0] ACT_ENQUEUE   = 3'd0;
    localparam logic [OFQ_ACT_W-1:0] ACT_SERVE     = 3'd1;
    localparam logic [OFQ_ACT_W-1:0] ACT_CANCEL    = 3'd2;
    localparam logic [OFQ_ACT_W-1:0] ACT_LIST_PEND = 3'd3;
    localparam logic [OFQ_ACT_W-1:0] ACT_LIST_HIST = 3'd4;

    localparam logic [OFQ_STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [OFQ_STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [OFQ_STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OFQ_CUST_W-1:0]  cust;
        logic [OFQ_ITEM_W-1:0]  item;
        logic [OFQ_PRICE_W-1:0] price;
    } ofq_rec_t;

    typedef struct packed {
        logic                    load;
        logic                    do_enq;
        logic                    do_serve;
        logic                    do_cancel;
        logic                    step;
        logic                    emit;
        logic [OFQ_STATUS_W-1:0] emit_status;
        logic                    emit_rec;
        logic                    emit_list;
    } ofq_cmd_t;

    typedef struct packed {
        logic [OFQ_ACT_W-1:0] action;
        logic                 pend_empty;
        logic                 pend_full;
        logic                 hist_empty;
        logic                 list_last;
        logic                 out_free;
    } ofq_stat_t;

endpackage

// ===== rtl/core/ofq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ofq_ctrl
// Controller of the order queue: decodes each action and sequences the
// datapath through updates, record fetches and listing walks.
// ----------------------------------------------------------------------------
module ofq_ctrl import ofq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ofq_stat_t stat,
    output ofq_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SERVE  = 5'b00100,
        S_LIST   = 5'b01000,
        S_LWAIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_status = ST_OK;
        s_tready        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (stat.action)
                    ACT_ENQUEUE: begin
                        if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = stat.pend_full ? ST_FULL : ST_OK;
                            cmd.do_enq      = !stat.pend_full;
                            state_next      = S_IDLE;
                        end
                    end
                    ACT_CANCEL: begin
                        if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = stat.pend_empty ? ST_EMPTY : ST_OK;
                            cmd.do_cancel   = !stat.pend_empty;
                            state_next      = S_IDLE;
                        end
                    end
                    ACT_SERVE, ACT_LIST_PEND: begin
                        if (!stat.pend_empty) begin
                            state_next = (stat.action == ACT_SERVE) ? S_SERVE : S_LIST;
                        end else if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_EMPTY;
                            state_next      = S_IDLE;
                        end
                    end
                    ACT_LIST_HIST: begin
                        if (!stat.hist_empty) begin
                            state_next = S_LIST;
                        end else if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_EMPTY;
                            state_next      = S_IDLE;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SERVE: begin
                if (stat.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_rec = 1'b1;
                    cmd.do_serve = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_LIST: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_rec  = 1'b1;
                    cmd.emit_list = 1'b1;
                    cmd.step      = 1'b1;
                    state_next    = stat.list_last ? S_IDLE : S_LWAIT;
                end
            end
            S_LWAIT: begin
                state_next = S_LIST;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/ofq_datapath.sv =====
// ----------------------------------------------------------------------------
// ofq_datapath
// Pending and history memories, their pointers and counts, the listing
// walk pointers and the result register.
// ----------------------------------------------------------------------------
module ofq_datapath import ofq_pkg::*; #(
    parameter int QUEUE_DEPTH   = OFQ_QUEUE_DEPTH,
    parameter int HISTORY_DEPTH = OFQ_HISTORY_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [OFQ_ACT_W-1:0]    s_action,
    input  ofq_rec_t                s_rec,
    input  ofq_cmd_t                cmd,
    output ofq_stat_t               stat,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic [OFQ_STATUS_W-1:0] m_status,
    output ofq_rec_t                m_rec,
    output logic [OFQ_POS_W-1:0]    m_position,
    output logic                    m_last
);

    localparam int QIW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int HIW = $clog2(HISTORY_DEPTH);
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW  = QCW + 1;
    localparam int LW0 = (QCW > HCW) ? QCW : HCW;
    localparam int LW  = (LW0 > OFQ_POS_W) ? LW0 : OFQ_POS_W;

    ofq_rec_t pend_mem [QUEUE_DEPTH];
    ofq_rec_t hist_mem [HISTORY_DEPTH];

    logic [OFQ_ACT_W-1:0]    action_reg;
    ofq_rec_t                in_rec_reg;
    logic [QIW-1:0]          head_reg, head_next;
    logic [QCW-1:0]          pcnt_reg, pcnt_next;
    logic [HIW-1:0]          top_reg, top_next;
    logic [HCW-1:0]          hcnt_reg, hcnt_next;
    logic [QIW-1:0]          p_ptr_reg, p_ptr_next;
    logic [HIW-1:0]          h_ptr_reg, h_ptr_next;
    logic [OFQ_POS_W-1:0]    pos_reg, pos_next;
    ofq_rec_t                p_rdata_reg;
    ofq_rec_t                h_rdata_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [OFQ_STATUS_W-1:0] out_status_reg;
    ofq_rec_t                out_rec_reg;
    logic [OFQ_POS_W-1:0]    out_pos_reg;
    logic                    out_last_reg;

    logic [SW-1:0]           tail_sum;
    logic [QIW-1:0]          tail_addr;
    logic [HIW-1:0]          top_prev;
    logic                    pend_full;
    logic                    hist_full;
    logic [LW-1:0]           list_cnt;
    logic                    list_last;
    logic                    out_free;
    ofq_rec_t                sel_rec;

    assign tail_sum  = SW'(head_reg) + SW'(pcnt_reg);
    assign tail_addr = (tail_sum >= SW'(QUEUE_DEPTH)) ? QIW'(tail_sum - SW'(QUEUE_DEPTH))
                                                      : QIW'(tail_sum);
    assign top_prev  = (top_reg == '0) ? HIW'(HISTORY_DEPTH - 1) : top_reg - 1'b1;
    assign pend_full = (pcnt_reg == QCW'(QUEUE_DEPTH));
    assign hist_full = (hcnt_reg == HCW'(HISTORY_DEPTH));
    assign list_cnt  = (action_reg == ACT_LIST_HIST) ? LW'(hcnt_reg) : LW'(pcnt_reg);
    assign list_last = (pos_reg == OFQ_POS_W'(OFQ_MAX_RESULTS)) || (LW'(pos_reg) == list_cnt);
    assign out_free  = !m_valid_reg || m_tready;
    assign sel_rec   = (action_reg == ACT_LIST_HIST) ? h_rdata_reg : p_rdata_reg;

    always_comb begin
        stat.action     = action_reg;
        stat.pend_empty = (pcnt_reg == '0);
        stat.pend_full  = pend_full;
        stat.hist_empty = (hcnt_reg == '0);
        stat.list_last  = list_last;
        stat.out_free   = out_free;
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_enq) begin
            pend_mem[tail_addr] <= in_rec_reg;
        end
        p_rdata_reg <= pend_mem[p_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_serve) begin
            hist_mem[top_reg] <= p_rdata_reg;
        end
        h_rdata_reg <= hist_mem[h_ptr_reg];
    end

    always_comb begin
        head_next  = head_reg;
        pcnt_next  = pcnt_reg;
        top_next   = top_reg;
        hcnt_next  = hcnt_reg;
        p_ptr_next = p_ptr_reg;
        h_ptr_next = h_ptr_reg;
        pos_next   = pos_reg;
        if (cmd.do_enq) begin
            pcnt_next = pcnt_reg + 1'b1;
        end
        if (cmd.do_cancel) begin
            pcnt_next = pcnt_reg - 1'b1;
        end
        if (cmd.do_serve) begin
            head_next = (head_reg == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            pcnt_next = pcnt_reg - 1'b1;
            top_next  = (top_reg == HIW'(HISTORY_DEPTH - 1)) ? '0 : top_reg + 1'b1;
            if (!hist_full) begin
                hcnt_next = hcnt_reg + 1'b1;
            end
        end
        if (cmd.load) begin
            p_ptr_next = head_reg;
            h_ptr_next = top_prev;
            pos_next   = OFQ_POS_W'(1);
        end else if (cmd.step) begin
            p_ptr_next = (p_ptr_reg == QIW'(QUEUE_DEPTH - 1)) ? '0 : p_ptr_reg + 1'b1;
            h_ptr_next = (h_ptr_reg == '0) ? HIW'(HISTORY_DEPTH - 1) : h_ptr_reg - 1'b1;
            pos_next   = pos_reg + 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            pcnt_reg    <= '0;
            top_reg     <= '0;
            hcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            pcnt_reg    <= pcnt_next;
            top_reg     <= top_next;
            hcnt_reg    <= hcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_ptr_reg <= p_ptr_next;
        h_ptr_reg <= h_ptr_next;
        pos_reg   <= pos_next;
        if (cmd.load) begin
            action_reg <= s_action;
            in_rec_reg <= s_rec;
        end
        if (cmd.emit) begin
            out_status_reg <= cmd.emit_status;
            out_rec_reg    <= cmd.emit_rec ? sel_rec : '0;
            out_pos_reg    <= cmd.emit_list ? pos_reg : '0;
            out_last_reg   <= cmd.emit_list ? list_last : 1'b1;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_status   = out_status_reg;
    assign m_rec      = out_rec_reg;
    assign m_position = out_pos_reg;
    assign m_last     = out_last_reg;

    a_pcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pcnt_reg <= QCW'(QUEUE_DEPTH))
        else $error("pending count exceeds queue depth");

    a_hcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hcnt_reg <= HCW'(HISTORY_DEPTH))
        else $error("history count exceeds history depth");

    a_enq_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_enq |-> !pend_full)
        else $error("enqueue written into a full queue");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("result register overwritten before its beat was taken");

    a_serve_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_serve |=> pcnt_reg == QCW'($past(pcnt_reg) - 1'b1))
        else $error("serve did not remove exactly one pending entry");

endmodule

// ===== rtl/core/order_fifo_tail_cancel_history_core.sv =====
// ----------------------------------------------------------------------------
// order_fifo_tail_cancel_history_core
// Bounded queue of order records with cancel of the newest entry, serve
// into a served-history stack, and listings of both stores.
//
// Channel  Dir  Beat contents
// s_       in   tuser: action; tdata: customer, item, price
// m_       out  tuser: status; tdata: customer, item, price, position;
//               tlast: last result of the action
//
// An action is taken only in the idle state, one at a time. Enqueue, cancel,
// an unused action code and any action on an empty store pass through the
// decide state only, serve goes on to the serve state, and a listing
// alternates list and wait states for the registered memory read ports.
// Reset clears the counts and the head and top pointers; memory contents stay
// undefined until written. A stalled result beat holds the controller
// until it is taken, while the next action can already be accepted.
// ----------------------------------------------------------------------------
module order_fifo_tail_cancel_history_core import ofq_pkg::*; #(
    parameter int QUEUE_DEPTH   = OFQ_QUEUE_DEPTH,
    parameter int HISTORY_DEPTH = OFQ_HISTORY_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // customer_id, item_code, price
    input  logic [2:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_customer, out_item, out_price, position
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast
);

    ofq_cmd_t             cmd;
    ofq_stat_t            stat;
    ofq_rec_t             s_rec;
    ofq_rec_t             m_rec;
    logic [OFQ_POS_W-1:0] m_position;

    assign s_rec.cust  = s_tdata[15:0];
    assign s_rec.item  = s_tdata[23:16];
    assign s_rec.price = s_tdata[47:24];

    ofq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ofq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_action   (s_tuser),
        .s_rec      (s_rec),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_status   (m_tuser),
        .m_rec      (m_rec),
        .m_position (m_position),
        .m_last     (m_tlast)
    );

    assign m_tdata = {3'b000, m_position, m_rec.price, m_rec.item, m_rec.cust};

endmodule
